// ----- sv/sll_pkg.sv -----
// Shared types, character codes and token kinds for the shell line lexer.
package sll_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'b001,
        MODE_SQUOTE = 3'b010,
        MODE_DQUOTE = 3'b100
    } mode_t;

    localparam logic [3:0] KIND_WORD      = 4'd0;
    localparam logic [3:0] KIND_PIPE      = 4'd1;
    localparam logic [3:0] KIND_PIPEPIPE  = 4'd2;
    localparam logic [3:0] KIND_LESS      = 4'd3;
    localparam logic [3:0] KIND_HEREDOC   = 4'd4;
    localparam logic [3:0] KIND_GREATER   = 4'd5;
    localparam logic [3:0] KIND_APPEND    = 4'd6;
    localparam logic [3:0] KIND_SEMICOLON = 4'd7;
    localparam logic [3:0] KIND_AND       = 4'd8;
    localparam logic [3:0] KIND_ANDAND    = 4'd9;

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam int RES_SLOTS = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic [3:0] token_kind;
        logic       token_end;
        logic       line_end;
        logic       status;
        logic       last;
    } result_t;

    typedef struct packed {
        mode_t      mode;
        logic       word_open;
        logic [7:0] held_op;
        logic       held_valid;
    } lex_state_t;

    function automatic logic [3:0] single_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_PIPE:  k = KIND_PIPE;
            CH_LESS:  k = KIND_LESS;
            CH_GREAT: k = KIND_GREATER;
            CH_AMP:   k = KIND_AND;
            default:  k = KIND_WORD;
        endcase
        return k;
    endfunction

    function automatic result_t mk_result(input logic [7:0] b, input logic bv,
                                          input logic [3:0] kind, input logic tend);
        result_t r;
        r.data_byte  = b;
        r.byte_valid = bv;
        r.token_kind = kind;
        r.token_end  = tend;
        r.line_end   = 1'b0;
        r.status     = 1'b0;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// ----- sv/sll_step.sv -----
// Per-byte lexer decision: next state and up to three results for one request.
module sll_step
    import sll_pkg::*;
(
    input  lex_state_t       state_i,
    input  logic [7:0]       ch_i,
    input  logic             eol_i,
    output lex_state_t       state_o,
    output result_t [2:0]    res_o,
    output logic [1:0]       count_o
);

    always_comb begin
        lex_state_t st;
        result_t [2:0] res;
        logic [1:0] n;
        logic [7:0] q;
        logic [3:0] k;
        logic consumed;
        logic err;

        st       = state_i;
        res      = '0;
        n        = 2'd0;
        err      = 1'b0;
        consumed = 1'b0;
        q        = (st.mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
        k        = single_kind(st.held_op);

        if (st.mode == MODE_SQUOTE || st.mode == MODE_DQUOTE) begin
            if (ch_i == q) begin
                res[n]  = mk_result(8'd0, 1'b0, KIND_WORD, 1'b1);
                n       = n + 2'd1;
                st.mode = MODE_PLAIN;
            end else begin
                res[n] = mk_result(ch_i, 1'b1, KIND_WORD, 1'b0);
                n      = n + 2'd1;
            end
        end else begin
            st.mode = MODE_PLAIN;
            if (st.held_valid) begin
                st.held_valid = 1'b0;
                if (ch_i == st.held_op) begin
                    res[n]   = mk_result(8'd0, 1'b0, k + 4'd1, 1'b1);
                    n        = n + 2'd1;
                    consumed = 1'b1;
                end else begin
                    res[n] = mk_result(8'd0, 1'b0, k, 1'b1);
                    n      = n + 2'd1;
                end
            end
            if (!consumed) begin
                if (ch_i == CH_SPACE || single_kind(ch_i) != KIND_WORD || ch_i == CH_SEMI
                        || ch_i == CH_SQUOTE || ch_i == CH_DQUOTE) begin
                    if (st.word_open) begin
                        res[n]       = mk_result(8'd0, 1'b0, KIND_WORD, 1'b1);
                        n            = n + 2'd1;
                        st.word_open = 1'b0;
                    end
                    if (single_kind(ch_i) != KIND_WORD) begin
                        st.held_op    = ch_i;
                        st.held_valid = 1'b1;
                    end else if (ch_i == CH_SEMI) begin
                        res[n] = mk_result(8'd0, 1'b0, KIND_SEMICOLON, 1'b1);
                        n      = n + 2'd1;
                    end else if (ch_i == CH_SQUOTE) begin
                        st.mode = MODE_SQUOTE;
                    end else if (ch_i == CH_DQUOTE) begin
                        st.mode = MODE_DQUOTE;
                    end
                end else begin
                    res[n]       = mk_result(ch_i, 1'b1, KIND_WORD, 1'b0);
                    n            = n + 2'd1;
                    st.word_open = 1'b1;
                end
            end
        end

        if (eol_i) begin
            if (st.held_valid) begin
                res[n]        = mk_result(8'd0, 1'b0, single_kind(st.held_op), 1'b1);
                n             = n + 2'd1;
                st.held_valid = 1'b0;
            end
            if (st.word_open) begin
                res[n]       = mk_result(8'd0, 1'b0, KIND_WORD, 1'b1);
                n            = n + 2'd1;
                st.word_open = 1'b0;
            end
            if (st.mode != MODE_PLAIN) begin
                err     = 1'b1;
                st.mode = MODE_PLAIN;
            end
            st.held_op = 8'd0;
            if (n == 2'd0) begin
                res[n] = mk_result(8'd0, 1'b0, KIND_WORD, 1'b0);
                n      = n + 2'd1;
            end
            res[n - 2'd1].line_end = 1'b1;
            res[n - 2'd1].status   = err;
        end

        if (n != 2'd0) begin
            res[n - 2'd1].last = 1'b1;
        end

        state_o = st;
        res_o   = res;
        count_o = n;
    end

endmodule

// ----- sv/shell_line_lexer.sv -----
// Top level of the shell line lexer: state registers and result buffer.
// The results of a request are registered when it is accepted and offered from the next cycle.
// One request per cycle while each gives at most one result and the result side is
// ready; a request that gives more results (up to three) holds the input until the
// single result port has drained them from the three-entry buffer.
// Reset: synchronous aresetn clears lexer mode, word and held operator, empties buffer.
module shell_line_lexer
    import sll_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // last_of_line
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [7:0] m_tuser,   // [0] byte_valid, [4:1] token_kind, [5] token_end,
                                  // [6] line_end, [7] status
    output logic       m_tlast    // last
);

    lex_state_t    state_reg, state_next;
    result_t [2:0] step_res;
    logic [1:0]    step_count;
    result_t       res_reg [RES_SLOTS];
    logic [1:0]    cnt_reg;
    logic [1:0]    idx_reg;
    result_t       cur;
    logic          s_acc;
    logic          m_acc;
    logic          drain_last;

    sll_step u_step (
        .state_i (state_reg),
        .ch_i    (s_tdata),
        .eol_i   (s_tlast),
        .state_o (state_next),
        .res_o   (step_res),
        .count_o (step_count)
    );

    assign cur        = res_reg[idx_reg];
    assign m_tvalid   = (cnt_reg != 2'd0);
    assign m_acc      = m_tvalid && m_tready;
    assign drain_last = (idx_reg + 2'd1 == cnt_reg);
    assign s_tready   = (cnt_reg == 2'd0) || (m_tready && drain_last);
    assign s_acc      = s_tvalid && s_tready;

    assign m_tdata = cur.data_byte;
    assign m_tuser = {cur.status, cur.line_end, cur.token_end, cur.token_kind, cur.byte_valid};
    assign m_tlast = cur.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_PLAIN, word_open: 1'b0, held_op: 8'd0,
                           held_valid: 1'b0};
            cnt_reg   <= 2'd0;
            idx_reg   <= 2'd0;
        end else if (s_acc) begin
            state_reg <= state_next;
            cnt_reg   <= step_count;
            idx_reg   <= 2'd0;
        end else if (m_acc) begin
            if (drain_last) begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // hold payload until the next request loads it
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            res_reg[0] <= step_res[0];
            res_reg[1] <= step_res[1];
            res_reg[2] <= step_res[2];
        end
    end

endmodule

// ----- bench/tb_shell_line_lexer.sv -----
// Self-checking bench for the shell line lexer: byte stream in, token results checked in order.
module tb_shell_line_lexer
    import sll_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 50;

    class lexer_scoreboard;
        result_t    expected_q[$];
        result_t    step_q[$];
        int         errors;
        int         results_seen;
        mode_t      mode;
        logic       word_open;
        logic [7:0] held_op;
        logic       held_valid;

        function new();
            errors       = 0;
            results_seen = 0;
            mode         = MODE_PLAIN;
            word_open    = 1'b0;
            held_op      = 8'h00;
            held_valid   = 1'b0;
        endfunction

        function logic [3:0] op_kind(logic [7:0] c);
            case (c)
                CH_PIPE:  return KIND_PIPE;
                CH_LESS:  return KIND_LESS;
                CH_GREAT: return KIND_GREATER;
                CH_AMP:   return KIND_AND;
                default:  return KIND_WORD;
            endcase
        endfunction

        function void emit(logic [7:0] b, logic bv, logic [3:0] kind, logic tend);
            result_t r;
            if (step_q.size() >= RES_SLOTS) return;
            r            = '0;
            r.data_byte  = b;
            r.byte_valid = bv;
            r.token_kind = kind;
            r.token_end  = tend;
            step_q.push_back(r);
        endfunction

        function void close_word();
            if (word_open) begin
                emit(8'h00, 1'b0, KIND_WORD, 1'b1);
                word_open = 1'b0;
            end
        endfunction

        function void plain_byte(logic [7:0] c);
            if (c == CH_SPACE) begin
                close_word();
            end else if (op_kind(c) != KIND_WORD) begin
                close_word();
                held_op    = c;
                held_valid = 1'b1;
            end else if (c == CH_SEMI) begin
                close_word();
                emit(8'h00, 1'b0, KIND_SEMICOLON, 1'b1);
            end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                close_word();
                mode = (c == CH_SQUOTE) ? MODE_SQUOTE : MODE_DQUOTE;
            end else begin
                emit(c, 1'b1, KIND_WORD, 1'b0);
                word_open = 1'b1;
            end
        endfunction

        function void note_request(logic [7:0] c, logic eol);
            logic       err;
            logic       taken;
            logic [7:0] closer;
            result_t    r;
            step_q.delete();
            err = 1'b0;
            if (mode == MODE_SQUOTE || mode == MODE_DQUOTE) begin
                closer = (mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
                if (c == closer) begin
                    emit(8'h00, 1'b0, KIND_WORD, 1'b1);
                    mode = MODE_PLAIN;
                end else begin
                    emit(c, 1'b1, KIND_WORD, 1'b0);
                end
            end else begin
                taken = 1'b0;
                mode  = MODE_PLAIN;
                if (held_valid) begin
                    held_valid = 1'b0;
                    if (c == held_op) begin
                        emit(8'h00, 1'b0, op_kind(held_op) + 4'd1, 1'b1);
                        taken = 1'b1;
                    end else begin
                        emit(8'h00, 1'b0, op_kind(held_op), 1'b1);
                    end
                end
                if (!taken) plain_byte(c);
            end
            if (eol) begin
                if (held_valid) begin
                    emit(8'h00, 1'b0, op_kind(held_op), 1'b1);
                    held_valid = 1'b0;
                end
                close_word();
                if (mode != MODE_PLAIN) begin
                    err  = 1'b1;
                    mode = MODE_PLAIN;
                end
                held_op = 8'h00;
                if (step_q.size() == 0) emit(8'h00, 1'b0, KIND_WORD, 1'b0);
                r          = step_q[step_q.size() - 1];
                r.line_end = 1'b1;
                r.status   = err;
                step_q[step_q.size() - 1] = r;
            end
            if (step_q.size() > 0) begin
                r      = step_q[step_q.size() - 1];
                r.last = 1'b1;
                step_q[step_q.size() - 1] = r;
            end
            foreach (step_q[i]) expected_q.push_back(step_q[i]);
        endfunction

        task report(string field, logic [7:0] got, logic [7:0] want);
            errors++;
            if (errors <= 200)
                $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                         results_seen, field, got, want);
        endtask

        task check_result(logic [7:0] tdata, logic [7:0] tuser, logic tlast);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report("unexpected result, tdata", tdata, 8'h00);
                return;
            end
            want = expected_q.pop_front();
            if (tdata != want.data_byte)      report("data_byte", tdata, want.data_byte);
            if (tuser[0] != want.byte_valid)
                report("byte_valid", 8'(tuser[0]), 8'(want.byte_valid));
            if (tuser[4:1] != want.token_kind)
                report("token_kind", 8'(tuser[4:1]), 8'(want.token_kind));
            if (tuser[5] != want.token_end)
                report("token_end", 8'(tuser[5]), 8'(want.token_end));
            if (tuser[6] != want.line_end)
                report("line_end", 8'(tuser[6]), 8'(want.line_end));
            if (tuser[7] != want.status)
                report("status", 8'(tuser[7]), 8'(want.status));
            if (tlast != want.last)
                report("last", 8'(tlast), 8'(want.last));
        endtask
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [7:0] m_tuser;
    logic       m_tlast;

    lexer_scoreboard lexer = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int cycles         = 0;

    // {last_of_line, ch}
    logic [8:0] opening_seq [$] = '{
        {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CH_SPACE},
        {1'b0, CH_PIPE}, {1'b0, CH_PIPE}, {1'b0, CH_LESS}, {1'b0, CH_LESS},
        {1'b0, CH_GREAT}, {1'b0, CH_GREAT}, {1'b0, CH_AMP}, {1'b0, CH_AMP},
        {1'b0, CH_SEMI},
        {1'b0, 8'h78}, {1'b0, CH_SQUOTE}, {1'b0, CH_SPACE}, {1'b0, CH_SQUOTE},
        {1'b0, 8'h79}, {1'b0, CH_DQUOTE}, {1'b0, CH_DQUOTE},
        {1'b0, CH_LESS}, {1'b0, 8'h7A}, {1'b1, CH_GREAT},
        {1'b0, CH_DQUOTE}, {1'b1, 8'h71},
        {1'b1, CH_SPACE},
        {1'b0, CH_AMP}, {1'b1, 8'h61}
    };

    shell_line_lexer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) lexer.check_result(m_tdata, m_tuser, m_tlast);
    end

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return 8'($urandom_range(8'h61, 8'h7A));
        if (roll < 45) return CH_SPACE;
        if (roll < 65) begin
            case ($urandom_range(0, 4))
                0:       return CH_PIPE;
                1:       return CH_LESS;
                2:       return CH_GREAT;
                3:       return CH_AMP;
                default: return CH_SEMI;
            endcase
        end
        if (roll < 75) return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eol);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lexer.note_request(c, eol);
        items_sent++;
    endtask

    task automatic send_line();
        int         len;
        logic [7:0] c;
        logic [7:0] prev;
        len  = $urandom_range(1, 12);
        prev = CH_SPACE;
        for (int i = 0; i < len; i++) begin
            // repeat operator bytes often so that the doubled forms turn up
            if ((prev == CH_PIPE || prev == CH_LESS || prev == CH_GREAT || prev == CH_AMP)
                && $urandom_range(0, 1))
                c = prev;
            else
                c = pick_byte();
            send_byte(c, i == len - 1);
            prev = c;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (lexer.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int target;
        bit hold_done;
        hold_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_seq[i]) send_byte(opening_seq[i][7:0], opening_seq[i][8]);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 76; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 76; end
                default: begin src_idle_pct = 14; sink_stall_pct = 14; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                // hold off the result side while requests keep coming
                if (phase == 0 && !hold_done && items_sent + 35 >= target) begin
                    hold_requests++;
                    hold_done = 1'b1;
                end
                send_line();
            end
            drain_results();
        end

        repeat (16) @(posedge aclk);
        if (lexer.errors == 0 && lexer.expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
